// File: rtl/button_gesture_classifier_core_macros.svh
// assertion macros used by the checker file
`ifndef BUTTON_GESTURE_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define BGC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Types and constants shared by the button gesture classifier modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bgc_pkg;

  // item kinds
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SCAN = 1'b1
  } bgc_cmd_e;

  // gesture codes
  typedef enum logic [1:0] {
    GEST_PENDING = 2'd0,
    GEST_SINGLE  = 2'd1,
    GEST_DOUBLE  = 2'd2,
    GEST_LONG    = 2'd3
  } bgc_gesture_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SINGLE_CLICK = 3'd0,
    CFG_DOUBLE_CLICK = 3'd1,
    CFG_LONG_PRESS   = 3'd2,
    CFG_LONG_PRELOAD = 3'd3
  } bgc_cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned WatchW   = 8;
  localparam int unsigned KeyW     = 4;
  localparam int unsigned ShowW    = 14;

  localparam logic [WatchW-1:0] WATCH_MAX = 8'd255;

  localparam logic [CfgDataW-1:0] RST_SINGLE_CLICK = 8'd30;
  localparam logic [CfgDataW-1:0] RST_DOUBLE_CLICK = 8'd20;
  localparam logic [CfgDataW-1:0] RST_LONG_PRESS   = 8'd50;
  localparam logic [CfgDataW-1:0] RST_LONG_PRELOAD = 8'd15;

  localparam logic [ShowW-1:0] SHOW_SINGLE = 14'd1111;
  localparam logic [ShowW-1:0] SHOW_DOUBLE = 14'd2222;
  localparam logic [ShowW-1:0] SHOW_LONG   = 14'd3333;
  localparam logic [ShowW-1:0] SHOW_RESET  = 14'd9876;

  // input beat
  typedef struct packed {
    logic            cmd;
    logic            pressed;
    logic [KeyW-1:0] key;
  } bgc_in_t;

  // result beat
  typedef struct packed {
    logic [1:0]       gesture;
    logic [KeyW-1:0]  current_key;
    logic [ShowW-1:0] display_value;
  } bgc_out_t;

  // thresholds handed to the classifier
  typedef struct packed {
    logic [CfgDataW-1:0] single_click_ticks;
    logic [CfgDataW-1:0] double_click_ticks;
    logic [CfgDataW-1:0] long_press_ticks;
    logic [CfgDataW-1:0] long_release_preload;
  } bgc_cfg_t;

endpackage

`default_nettype wire

// File: rtl/bgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bgc_cfg_regs
// Threshold registers written through the configuration channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bgc_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bgc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [bgc_pkg::CfgDataW-1:0]    cfg_data_i,
  output bgc_pkg::bgc_cfg_t                    cfg_o
);

  bgc_pkg::bgc_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  // register decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (bgc_pkg::bgc_cfg_idx_e'(cfg_index_i))
        bgc_pkg::CFG_SINGLE_CLICK: cfg_d.single_click_ticks   = cfg_data_i;
        bgc_pkg::CFG_DOUBLE_CLICK: cfg_d.double_click_ticks   = cfg_data_i;
        bgc_pkg::CFG_LONG_PRESS:   cfg_d.long_press_ticks     = cfg_data_i;
        bgc_pkg::CFG_LONG_PRELOAD: cfg_d.long_release_preload = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.single_click_ticks   <= bgc_pkg::RST_SINGLE_CLICK;
      cfg_q.double_click_ticks   <= bgc_pkg::RST_DOUBLE_CLICK;
      cfg_q.long_press_ticks     <= bgc_pkg::RST_LONG_PRESS;
      cfg_q.long_release_preload <= bgc_pkg::RST_LONG_PRELOAD;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/bgc_classify.sv
// ----------------------------------------------------------------------------
// bgc_classify
// Gesture state registers and the combinational update for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bgc_classify (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire bgc_pkg::bgc_in_t  item_i,
  input  wire bgc_pkg::bgc_cfg_t cfg_i,
  output bgc_pkg::bgc_out_t      res_o
);

  logic [bgc_pkg::WatchW-1:0] watch_q, watch_d;
  logic                       armed_q, armed_d;
  bgc_pkg::bgc_gesture_e      gest_q, gest_d;
  logic [bgc_pkg::KeyW-1:0]   held_q, held_d;
  logic                       was_q, was_d;
  logic [bgc_pkg::ShowW-1:0]  shown_q, shown_d;
  logic                       key_same;

  // next state for a tick or a scan sample
  always_comb begin
    watch_d  = watch_q;
    armed_d  = armed_q;
    gest_d   = gest_q;
    held_d   = held_q;
    was_d    = was_q;
    shown_d  = shown_q;
    key_same = 1'b1;
    if (item_i.cmd == bgc_pkg::CMD_TICK) begin
      // saturating stopwatch
      if (watch_q != bgc_pkg::WATCH_MAX) begin
        watch_d = watch_q + 8'd1;
      end
    end else begin
      if (item_i.pressed) begin
        held_d = item_i.key;
      end
      key_same = (held_d == held_q);
      if (!key_same) begin
        shown_d = {{(bgc_pkg::ShowW-bgc_pkg::KeyW){1'b0}}, held_d};
      end
      case ({item_i.pressed, was_q})
        // idle: confirm single click after enough quiet time
        2'b00: begin
          if (armed_q && (watch_q >= cfg_i.single_click_ticks)) begin
            gest_d  = bgc_pkg::GEST_SINGLE;
            shown_d = bgc_pkg::SHOW_SINGLE;
          end
        end
        // release edge
        2'b01: begin
          if (gest_q == bgc_pkg::GEST_LONG) begin
            watch_d = cfg_i.long_release_preload;
            armed_d = 1'b0;
          end else begin
            watch_d = '0;
          end
        end
        // press edge: double click or arm
        2'b10: begin
          shown_d = {{(bgc_pkg::ShowW-bgc_pkg::KeyW){1'b0}}, held_d};
          if (armed_q && key_same && (watch_q <= cfg_i.double_click_ticks)) begin
            gest_d  = bgc_pkg::GEST_DOUBLE;
            armed_d = 1'b0;
            shown_d = bgc_pkg::SHOW_DOUBLE;
          end else begin
            gest_d  = bgc_pkg::GEST_PENDING;
            armed_d = 1'b1;
          end
          watch_d = '0;
        end
        // held: long press once the threshold is reached
        default: begin
          if (key_same && armed_q && (watch_q >= cfg_i.long_press_ticks)) begin
            gest_d  = bgc_pkg::GEST_LONG;
            shown_d = bgc_pkg::SHOW_LONG;
          end
        end
      endcase
      was_d = item_i.pressed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watch_q <= '0;
      armed_q <= 1'b0;
      gest_q  <= bgc_pkg::GEST_PENDING;
      held_q  <= '0;
      was_q   <= 1'b0;
      shown_q <= bgc_pkg::SHOW_RESET;
    end else if (step_i) begin
      watch_q <= watch_d;
      armed_q <= armed_d;
      gest_q  <= gest_d;
      held_q  <= held_d;
      was_q   <= was_d;
      shown_q <= shown_d;
    end
  end

  // result shows the state after the item
  assign res_o.gesture       = gest_d;
  assign res_o.current_key   = held_d;
  assign res_o.display_value = shown_d;

endmodule

`default_nettype wire

// File: rtl/button_gesture_classifier_core.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier_core
// Sorts keypad presses into single click, double click and long press.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes timer ticks and keypad scan samples, one beat
//   each, under valid/stall. Every input beat gives exactly one result beat
//   with the gesture code, the last pressed key and the display number.
//   A beat accepted into the input register is classified by the state
//   update, which writes the result register once the result side can take
//   it. Throughput is one beat per cycle while in_stall_o is low; the state
//   update is combinational compare and select logic.
//   When the receiver stalls, the result register holds its beat and the
//   input register can still take one more beat before in_stall_o rises.
//   The configuration channel is always ready; write it only while idle.
//   Reset clears both valid flags, loads the default thresholds and puts
//   the classifier in its start state, display 9876.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_gesture_classifier_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire bgc_pkg::bgc_in_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output bgc_pkg::bgc_out_t                  out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bgc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [bgc_pkg::CfgDataW-1:0]  cfg_data_i
);

  bgc_pkg::bgc_cfg_t cfg;
  bgc_pkg::bgc_in_t  in_q;
  logic              in_vld_q, in_vld_d;
  bgc_pkg::bgc_out_t out_q;
  bgc_pkg::bgc_out_t res;
  logic              out_vld_q, out_vld_d;
  logic              res_ready;
  logic              step;

  bgc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // handshake between the two registers
  assign res_ready  = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && res_ready;
  assign in_stall_o = in_vld_q && !res_ready;

  always_comb begin
    in_vld_d  = in_stall_o ? in_vld_q : in_valid_i;
    out_vld_d = res_ready ? step : out_vld_q;
  end

  bgc_classify u_classify (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/bgc_checker.sv
// ----------------------------------------------------------------------------
// bgc_checker
// Port-level checks for the gesture classifier, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "button_gesture_classifier_core_macros.svh"

module bgc_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_stall_o,
  input wire bgc_pkg::bgc_out_t out_data_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i
);

  // a stalled result beat holds
  `BGC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result beat changed")

  // input back-pressure only when the result register is full and stalled
  `BGC_ASSERT_SAME(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without a stalled result")

  // the double and long banners always come with their gesture code
  `BGC_ASSERT_SAME(a_show_double, clk_i, rst_ni, out_valid_o && (out_data_o.display_value == bgc_pkg::SHOW_DOUBLE), out_data_o.gesture == bgc_pkg::GEST_DOUBLE, "2222 shown without double click")

  `BGC_ASSERT_SAME(a_show_long, clk_i, rst_ni, out_valid_o && (out_data_o.display_value == bgc_pkg::SHOW_LONG), out_data_o.gesture == bgc_pkg::GEST_LONG, "3333 shown without long press")

endmodule

bind button_gesture_classifier_core bgc_checker u_bgc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for button_gesture_classifier_core. Ticks and keypad
// scan beats are sent in random bursts while the result side stalls on its
// own pattern. A behavioral copy of the classifier predicts every result
// beat, which is checked field by field. The run steps through several
// threshold settings, the default, zero and full-scale ones among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 4;
  localparam int REPORT_MAX  = 10;
  localparam logic [bgc_pkg::CfgIdxW-1:0] CFG_IDX_SPARE = 3'd6;

  // clock, reset and block ports
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bgc_pkg::bgc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bgc_pkg::bgc_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bgc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [bgc_pkg::CfgDataW-1:0] cfg_data = '0;

  // stimulus and checking bookkeeping
  bgc_pkg::bgc_in_t  scan_beats[$];
  bgc_pkg::bgc_out_t pending_results[$];
  int beats_queued = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  int settings_used = 1;
  int gesture_seen[4] = '{0, 0, 0, 0};
  bit in_taken = 1'b0;
  bit timed_out = 1'b0;

  // classifier copy: thresholds and state
  bgc_pkg::bgc_cfg_t thresh;
  logic [bgc_pkg::WatchW-1:0] watch_m;
  logic armed_m;
  bgc_pkg::bgc_gesture_e gesture_m;
  logic [bgc_pkg::KeyW-1:0] key_m;
  logic was_pressed_m;
  logic [bgc_pkg::ShowW-1:0] shown_m;

  button_gesture_classifier_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // advance the classifier copy by one input beat, return the result beat
  function automatic bgc_pkg::bgc_out_t classify_beat(bgc_pkg::bgc_in_t beat);
    logic [bgc_pkg::KeyW-1:0] prev_key;
    logic prev_pressed;
    bgc_pkg::bgc_out_t res;
    if (beat.cmd == bgc_pkg::CMD_TICK) begin
      if (watch_m != bgc_pkg::WATCH_MAX) watch_m = watch_m + 1'b1;
    end else begin
      prev_key = key_m;
      prev_pressed = was_pressed_m;
      if (beat.pressed) key_m = beat.key;
      if (key_m != prev_key)
        shown_m = {{(bgc_pkg::ShowW-bgc_pkg::KeyW){1'b0}}, key_m};
      if (!beat.pressed && !prev_pressed) begin
        // idle: confirm a single click once the wait has run out
        if (armed_m && watch_m >= thresh.single_click_ticks) begin
          gesture_m = bgc_pkg::GEST_SINGLE;
          shown_m = bgc_pkg::SHOW_SINGLE;
        end
      end else if (!beat.pressed) begin
        // release edge
        if (gesture_m == bgc_pkg::GEST_LONG) begin
          watch_m = thresh.long_release_preload;
          armed_m = 1'b0;
        end else begin
          watch_m = '0;
        end
      end else if (!prev_pressed) begin
        // press edge: second press of the same key in time is a double
        shown_m = {{(bgc_pkg::ShowW-bgc_pkg::KeyW){1'b0}}, key_m};
        if (armed_m && key_m == prev_key && watch_m <= thresh.double_click_ticks) begin
          gesture_m = bgc_pkg::GEST_DOUBLE;
          armed_m = 1'b0;
          shown_m = bgc_pkg::SHOW_DOUBLE;
        end else begin
          gesture_m = bgc_pkg::GEST_PENDING;
          armed_m = 1'b1;
        end
        watch_m = '0;
      end else begin
        // held
        if (key_m == prev_key && armed_m && watch_m >= thresh.long_press_ticks) begin
          gesture_m = bgc_pkg::GEST_LONG;
          shown_m = bgc_pkg::SHOW_LONG;
        end
      end
      was_pressed_m = beat.pressed;
    end
    res.gesture = gesture_m;
    res.current_key = key_m;
    res.display_value = shown_m;
    return res;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("[%0t] ERROR: %s", $time, msg);
  endtask

  // monitor: predict accepted input beats, check accepted result beats
  always @(posedge clk_i) begin
    bgc_pkg::bgc_out_t want;
    bit busy;
    busy = 1'b0;
    in_taken = rst_ni && in_valid && !in_stall;
    if (in_taken) begin
      pending_results.push_back(classify_beat(in_data));
      beats_sent++;
      busy = 1'b1;
    end
    if (rst_ni && out_valid && !out_stall) begin
      busy = 1'b1;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result beat with nothing pending: %p", out_data));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        gesture_seen[want.gesture]++;
        if (out_data.gesture !== want.gesture)
          note_failure($sformatf("gesture: expected %0d, got %0d",
                                 want.gesture, out_data.gesture));
        if (out_data.current_key !== want.current_key)
          note_failure($sformatf("current_key: expected %0d, got %0d",
                                 want.current_key, out_data.current_key));
        if (out_data.display_value !== want.display_value)
          note_failure($sformatf("display_value: expected %0d, got %0d",
                                 want.display_value, out_data.display_value));
      end
    end
    if (cfg_valid && cfg_ready) busy = 1'b1;
    idle_cycles = busy ? 0 : idle_cycles + 1;
  end

  // driver: bursts of beats with random gaps between them
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (gap_left > 0 || scan_beats.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_data <= scan_beats.pop_front();
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // result side stall, switching mode every so often
  int stall_cnt = 0;
  int stall_mode = 0;
  always @(negedge clk_i) begin
    stall_cnt++;
    if (stall_cnt % 150 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_cnt % 7 < 3);
    endcase
  end

  task automatic push_beat(bgc_pkg::bgc_cmd_e cmd, logic pressed,
                           logic [bgc_pkg::KeyW-1:0] key);
    bgc_pkg::bgc_in_t beat;
    beat.cmd = cmd;
    beat.pressed = pressed;
    beat.key = key;
    scan_beats.push_back(beat);
    beats_queued++;
  endtask

  // ticks carry random don't-care fields
  task automatic push_ticks(int n);
    repeat (n)
      push_beat(bgc_pkg::CMD_TICK, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
  endtask

  task automatic push_scan(logic pressed, logic [bgc_pkg::KeyW-1:0] key);
    push_beat(bgc_pkg::CMD_SCAN, pressed, key);
  endtask

  // mostly legal keys, now and then an out-of-range one
  function automatic logic [bgc_pkg::KeyW-1:0] pick_key();
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(1, 10));
  endfunction

  // tick count around a threshold, sometimes well below it
  function automatic int near_ticks(logic [bgc_pkg::CfgDataW-1:0] t);
    int v;
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, int'(t) + 5);
    v = int'(t) + $urandom_range(0, 6) - 3;
    return (v < 0) ? 0 : v;
  endfunction

  // one gesture sequence with random content, or noise
  task automatic push_gesture();
    logic [bgc_pkg::KeyW-1:0] k;
    logic [bgc_pkg::KeyW-1:0] k2;
    k = pick_key();
    k2 = pick_key();
    case ($urandom_range(0, 9))
      0, 1: begin
        // single click
        push_scan(1'b1, k);
        push_ticks($urandom_range(0, 3));
        if ($urandom_range(0, 1)) push_scan(1'b1, k);
        push_scan(1'b0, pick_key());
        push_ticks(near_ticks(thresh.single_click_ticks));
        push_scan(1'b0, pick_key());
        push_ticks($urandom_range(0, 3));
        push_scan(1'b0, pick_key());
      end
      2, 3: begin
        // double click
        push_scan(1'b1, k);
        push_ticks($urandom_range(0, 3));
        push_scan(1'b0, pick_key());
        push_ticks(near_ticks(thresh.double_click_ticks));
        push_scan(1'b1, k);
        push_ticks($urandom_range(0, 2));
        push_scan(1'b0, pick_key());
      end
      4, 5: begin
        // long press, then the wait after release
        push_scan(1'b1, k);
        push_ticks(near_ticks(thresh.long_press_ticks));
        push_scan(1'b1, k);
        push_ticks($urandom_range(0, 2));
        push_scan(1'b1, k);
        push_scan(1'b0, pick_key());
        push_ticks(near_ticks(thresh.single_click_ticks));
        push_scan(1'b0, pick_key());
      end
      6: begin
        // key changes while held
        push_scan(1'b1, k);
        push_ticks($urandom_range(0, 4));
        push_scan(1'b1, k2);
        push_scan(1'b0, pick_key());
        push_scan(1'b1, k2);
        push_scan(1'b0, pick_key());
      end
      7: begin
        // second press on another key
        push_scan(1'b1, k);
        push_scan(1'b0, pick_key());
        push_ticks($urandom_range(0, 3));
        push_scan(1'b1, k2);
        push_scan(1'b0, pick_key());
      end
      default: begin
        repeat ($urandom_range(1, 8))
          push_beat(bgc_pkg::bgc_cmd_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    4'($urandom_range(0, 15)));
      end
    endcase
  endtask

  // wait until every beat has gone through and its result has come back
  task automatic wait_idle();
    do @(posedge clk_i);
    while (scan_beats.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [bgc_pkg::CfgIdxW-1:0] idx,
                           logic [bgc_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i);
    while (!cfg_ready);
    case (idx)
      bgc_pkg::CFG_SINGLE_CLICK: thresh.single_click_ticks = data;
      bgc_pkg::CFG_DOUBLE_CLICK: thresh.double_click_ticks = data;
      bgc_pkg::CFG_LONG_PRESS:   thresh.long_press_ticks = data;
      bgc_pkg::CFG_LONG_PRELOAD: thresh.long_release_preload = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_thresholds(logic [bgc_pkg::CfgDataW-1:0] single,
                                logic [bgc_pkg::CfgDataW-1:0] dbl,
                                logic [bgc_pkg::CfgDataW-1:0] lng,
                                logic [bgc_pkg::CfgDataW-1:0] preload);
    write_reg(bgc_pkg::CFG_SINGLE_CLICK, single);
    write_reg(bgc_pkg::CFG_DOUBLE_CLICK, dbl);
    write_reg(bgc_pkg::CFG_LONG_PRESS, lng);
    write_reg(bgc_pkg::CFG_LONG_PRELOAD, preload);
    settings_used++;
  endtask

  task automatic run_gestures(int budget);
    int stop_at;
    stop_at = beats_queued + budget;
    while (beats_queued < stop_at) push_gesture();
    wait_idle();
  endtask

  initial begin
    thresh.single_click_ticks = bgc_pkg::RST_SINGLE_CLICK;
    thresh.double_click_ticks = bgc_pkg::RST_DOUBLE_CLICK;
    thresh.long_press_ticks = bgc_pkg::RST_LONG_PRESS;
    thresh.long_release_preload = bgc_pkg::RST_LONG_PRELOAD;
    watch_m = '0;
    armed_m = 1'b0;
    gesture_m = bgc_pkg::GEST_PENDING;
    key_m = '0;
    was_pressed_m = 1'b0;
    shown_m = bgc_pkg::SHOW_RESET;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        // directed: ignored key on release, out-of-range keys, key change
        // while held, a quick double click at the reset thresholds
        push_ticks(1);
        push_scan(1'b0, 4'hF);
        push_scan(1'b1, 4'h0);
        push_scan(1'b0, 4'h7);
        push_scan(1'b1, 4'hF);
        push_scan(1'b1, 4'hB);
        push_scan(1'b0, 4'h0);
        push_ticks(2);
        push_scan(1'b1, 4'hA);
        push_scan(1'b0, 4'h3);
        push_ticks(3);
        push_scan(1'b1, 4'hA);
        push_scan(1'b0, 4'hA);
        push_scan(1'b1, 4'h1);
        push_ticks(1);
        push_scan(1'b1, 4'h1);
        push_scan(1'b0, 4'h9);
        push_scan(1'b0, 4'h9);
        wait_idle();

        // random gestures at the reset thresholds
        run_gestures(120);

        // small thresholds, plus a write to an unused index
        set_thresholds(8'($urandom_range(0, 10)), 8'($urandom_range(0, 10)),
                       8'($urandom_range(0, 10)), 8'($urandom_range(0, 10)));
        write_reg(CFG_IDX_SPARE, 8'($urandom_range(0, 255)));
        run_gestures(180);

        // everything at zero
        set_thresholds(8'd0, 8'd0, 8'd0, 8'd0);
        run_gestures(80);

        // everything at full scale, stopwatch driven into saturation
        set_thresholds(8'd255, 8'd255, 8'd255, 8'd255);
        push_ticks(260);
        push_scan(1'b0, pick_key());
        run_gestures(40);

        // mixed moderate thresholds
        set_thresholds(8'($urandom_range(0, 60)), 8'($urandom_range(0, 60)),
                       8'($urandom_range(0, 60)), 8'($urandom_range(0, 255)));
        run_gestures(120);
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        timed_out = 1'b1;
      end
    join_any

    if (timed_out)
      $display("ERROR: no handshake for %0d cycles, %0d results still pending",
               IDLE_LIMIT, pending_results.size());
    else if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));

    $display("%0d input beats over %0d threshold settings, %0d results checked",
             beats_sent, settings_used, results_checked);
    $display("gestures seen: pending %0d, single %0d, double %0d, long %0d; %0d errors",
             gesture_seen[0], gesture_seen[1], gesture_seen[2], gesture_seen[3], fail_count);
    if (!timed_out && fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
